// ----- design/swlm_pkg.sv -----
`default_nettype none

package swlm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 5;

    localparam logic [CFG_W-1:0] WSIZE_RESET = 5'd3;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic del_le;
        logic cur_left;
    } t_link;

endpackage

`default_nettype wire

// ----- design/swlm_cell.sv -----
`default_nettype none

module swlm_cell #(
    parameter int AW = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_shift,
    input  wire                  i_clear,
    input  swlm_pkg::t_sample    i_sample,
    input  wire                  i_full,
    input  wire [AW-1:0]         i_kmax,
    input  swlm_pkg::t_link      i_prev_link,
    input  wire                  i_prev_valid,
    input  swlm_pkg::t_sample    i_prev_value,
    input  wire [AW-1:0]         i_prev_age,
    input  wire                  i_next_left,
    input  wire                  i_next_valid,
    input  swlm_pkg::t_sample    i_next_value,
    input  wire [AW-1:0]         i_next_age,
    output swlm_pkg::t_link      o_link,
    output logic                 o_left,
    output logic                 o_valid,
    output swlm_pkg::t_sample    o_value,
    output logic [AW-1:0]        o_age,
    output swlm_pkg::t_sample    o_new_value
);
    import swlm_pkg::*;

    logic          r_valid;
    t_sample       r_value;
    logic [AW-1:0] r_age;
    logic          n_valid;
    t_sample       n_value;
    logic [AW-1:0] n_age;

    logic          del;
    logic          left;
    logic          dle;
    logic          c_valid;
    t_sample       c_value;
    logic [AW-1:0] c_age;
    logic          c_left;
    logic          p_valid;
    t_sample       p_value;
    logic [AW-1:0] p_age;

    always_comb begin
        del     = r_valid && i_full && (r_age == i_kmax);
        left    = r_valid && !del && (r_value <= i_sample);
        dle     = i_prev_link.del_le || del;
        c_valid = dle ? i_next_valid : r_valid;
        c_value = dle ? i_next_value : r_value;
        c_age   = dle ? i_next_age   : r_age;
        c_left  = dle ? i_next_left  : left;
        p_valid = i_prev_link.del_le ? r_valid : i_prev_valid;
        p_value = i_prev_link.del_le ? r_value : i_prev_value;
        p_age   = i_prev_link.del_le ? r_age   : i_prev_age;
        priority if (c_left) begin
            n_valid = c_valid;
            n_value = c_value;
            n_age   = c_age + AW'(1);
        end else if (i_prev_link.cur_left) begin
            n_valid = 1'b1;
            n_value = i_sample;
            n_age   = '0;
        end else begin
            n_valid = p_valid;
            n_value = p_value;
            n_age   = p_age + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

    assign o_link.del_le   = dle;
    assign o_link.cur_left = c_left;
    assign o_left          = left;
    assign o_valid         = r_valid;
    assign o_value         = r_value;
    assign o_age           = r_age;
    assign o_new_value     = n_value;

endmodule

`default_nettype wire

// ----- design/sliding_window_lower_median_core.sv -----
// Sliding-window lower median filter.
// Slave stream: i_s_tdata carries a signed 16-bit sample, i_s_tlast marks the
// last sample of a sequence. Master stream: o_m_tdata carries the lower median
// (sorted position (k-1)/2) of the last k samples, o_m_tlast is set when the
// median comes from a sequence's last sample.
// No word leaves until k samples have been taken since the window was last
// emptied; after that every sample yields one word. The window empties after
// a last sample and on every write of the window size (i_cfg_wen, i_cfg_wdata);
// a size of 0 acts as 1 and one above MAX_WINDOW acts as MAX_WINDOW.
// The window lives in a sorted row of MAX_WINDOW cells, each holding a sample
// and its age; a new sample drops the oldest and slots into place.
// A median word is valid in the cycle after its sample is accepted;
// throughput is one sample per cycle while the receiver takes each word.
// o_s_tready is high while the output register is empty or being taken, so a
// stalled receiver holds the word and the input stalls behind it.
// Reset (i_rst_n low, synchronous) empties the window, drops any pending word
// and sets the window size to 3.
`default_nettype none

module sliding_window_lower_median_core #(
    parameter int MAX_WINDOW = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_tvalid,
    output logic                            o_s_tready,
    input  wire [15:0]                      i_s_tdata,   // [15:0] sample
    input  wire                             i_s_tlast,
    output logic                            o_m_tvalid,
    input  wire                             i_m_tready,
    output logic [15:0]                     o_m_tdata,   // [15:0] median
    output logic                            o_m_tlast,
    input  wire                             i_cfg_wen,
    input  wire [swlm_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import swlm_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int KW = $clog2(MAX_WINDOW + 1);

    logic [CFG_W-1:0] r_wsize;
    logic [KW-1:0]    r_fill;
    logic [KW-1:0]    n_fill;
    logic             r_out_valid;
    t_sample          r_out_median;
    logic             r_out_last;

    logic             accept;
    logic             clear;
    logic             full;
    logic [KW-1:0]    k;
    logic [AW-1:0]    kmax;
    logic [AW-1:0]    mid;
    t_sample          sample;

    t_link            link   [MAX_WINDOW];
    logic             lefts  [MAX_WINDOW];
    logic             valids [MAX_WINDOW];
    t_sample          values [MAX_WINDOW];
    logic [AW-1:0]    ages   [MAX_WINDOW];
    t_sample          nvals  [MAX_WINDOW];

    assign sample     = t_sample'(i_s_tdata);
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign clear      = i_cfg_wen || (accept && i_s_tlast);

    always_comb begin
        if (r_wsize == '0) begin
            k = KW'(1);
        end else if (32'(r_wsize) > 32'(MAX_WINDOW)) begin
            k = KW'(MAX_WINDOW);
        end else begin
            k = KW'(r_wsize);
        end
        kmax   = AW'(k - KW'(1));
        mid    = kmax >> 1;
        full   = (r_fill == k);
        n_fill = (r_fill < k) ? r_fill + KW'(1) : r_fill;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_WINDOW; g++) begin : g_cell
            t_link         prev_link;
            logic          prev_valid;
            t_sample       prev_value;
            logic [AW-1:0] prev_age;
            logic          next_left;
            logic          next_valid;
            t_sample       next_value;
            logic [AW-1:0] next_age;

            if (g == 0) begin : g_head
                assign prev_link.del_le   = 1'b0;
                assign prev_link.cur_left = 1'b1;
                assign prev_valid         = 1'b0;
                assign prev_value         = '0;
                assign prev_age           = '0;
            end else begin : g_body
                assign prev_link  = link[g-1];
                assign prev_valid = valids[g-1];
                assign prev_value = values[g-1];
                assign prev_age   = ages[g-1];
            end

            if (g == MAX_WINDOW - 1) begin : g_tail
                assign next_left  = 1'b0;
                assign next_valid = 1'b0;
                assign next_value = '0;
                assign next_age   = '0;
            end else begin : g_inner
                assign next_left  = lefts[g+1];
                assign next_valid = valids[g+1];
                assign next_value = values[g+1];
                assign next_age   = ages[g+1];
            end

            swlm_cell #(
                .AW (AW)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_shift      (accept),
                .i_clear      (clear),
                .i_sample     (sample),
                .i_full       (full),
                .i_kmax       (kmax),
                .i_prev_link  (prev_link),
                .i_prev_valid (prev_valid),
                .i_prev_value (prev_value),
                .i_prev_age   (prev_age),
                .i_next_left  (next_left),
                .i_next_valid (next_valid),
                .i_next_value (next_value),
                .i_next_age   (next_age),
                .o_link       (link[g]),
                .o_left       (lefts[g]),
                .o_valid      (valids[g]),
                .o_value      (values[g]),
                .o_age        (ages[g]),
                .o_new_value  (nvals[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize <= WSIZE_RESET;
            r_fill  <= '0;
        end else begin
            if (i_cfg_wen) begin
                r_wsize <= i_cfg_wdata;
            end
            if (clear) begin
                r_fill <= '0;
            end else if (accept) begin
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= (n_fill == k);
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_median <= nvals[mid];
            r_out_last   <= i_s_tlast;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_median;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

// ----- design/swlm_checker.sv -----
`default_nettype none

module swlm_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_tvalid,
    input wire        o_s_tready,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [15:0] o_m_tdata,
    input wire        o_m_tlast
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output word present after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    a_word_from_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !$past(o_m_tvalid && !i_m_tready)) |->
            $past(i_s_tvalid && o_s_tready))
        else $error("output word without an accepted sample");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("stalled output word changed");

endmodule

bind sliding_window_lower_median_core swlm_checker u_swlm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

// ----- tb/sliding_window_lower_median_core_tb.sv -----
`timescale 1ns / 1ps

module sliding_window_lower_median_core_tb;

    import swlm_pkg::*;

    localparam int WIN_MAX    = 16;
    localparam int N_PHASES   = 12;
    localparam int PHASE_LEN  = 42;

    class median_scoreboard;
        t_sample     win [WIN_MAX];
        int unsigned fill;
        int unsigned slot;
        logic [CFG_W-1:0] wsize;
        t_sample     exp_median [$];
        bit          exp_last [$];
        int          errors;

        function new();
            wsize  = WSIZE_RESET;
            fill   = 0;
            slot   = 0;
            errors = 0;
        endfunction

        function int unsigned win_len();
            if (wsize == 0)
                return 1;
            if (wsize > WIN_MAX)
                return WIN_MAX;
            return wsize;
        endfunction

        function void set_size(logic [CFG_W-1:0] v);
            wsize = v;
            fill  = 0;
            slot  = 0;
        endfunction

        function void note_sample(t_sample s, bit last);
            int unsigned k;
            t_sample     srt [WIN_MAX];
            t_sample     v;
            int          i;
            int          j;
            k = win_len();
            if (slot >= k)
                slot = 0;
            win[slot] = s;
            slot++;
            if (slot >= k)
                slot = 0;
            if (fill < k)
                fill++;
            if (fill >= k) begin
                for (i = 0; i < k; i++)
                    srt[i] = win[i];
                for (i = 1; i < k; i++) begin
                    v = srt[i];
                    j = i;
                    while (j > 0 && srt[j-1] > v) begin
                        srt[j] = srt[j-1];
                        j--;
                    end
                    srt[j] = v;
                end
                exp_median = {exp_median, srt[(k-1)/2]};
                exp_last   = {exp_last, last};
            end
            if (last) begin
                fill = 0;
                slot = 0;
            end
        endfunction

        function void check_word(logic [15:0] m, bit last);
            t_sample e_m;
            bit      e_l;
            if (exp_median.size() == 0) begin
                $display("%0t: unexpected word median %0d last %0b", $time, $signed(m), last);
                errors++;
                return;
            end
            e_m = exp_median.pop_front();
            e_l = exp_last.pop_front();
            if (m !== e_m) begin
                $display("%0t: median expected %0d got %0d", $time, e_m, $signed(m));
                errors++;
            end
            if (last !== e_l) begin
                $display("%0t: tlast expected %0b got %0b", $time, e_l, last);
                errors++;
            end
        endfunction

        function int pending();
            return exp_median.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [15:0]       i_s_tdata;   // [15:0] sample
    logic              i_s_tlast;
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [15:0]       o_m_tdata;   // [15:0] median
    logic              o_m_tlast;
    logic              i_cfg_wen;
    logic [CFG_W-1:0]  i_cfg_wdata;

    median_scoreboard sb;
    int               src_idle_pct;
    int               snk_stall_pct;
    int               hold_len;

    sliding_window_lower_median_core #(
        .MAX_WINDOW (WIN_MAX)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("sliding_window_lower_median_core_tb: FAIL");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        i_m_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_len != 0) begin
                i_m_tready = 1'b0;
                repeat (hold_len) @(negedge i_clk);
                hold_len = 0;
            end
            i_m_tready = ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_word(o_m_tdata, o_m_tlast);
    end

    task automatic send_word(input t_sample s, input bit last);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = s;
        i_s_tlast  = last;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_sample(s, last);
    endtask

    // drop valid, drain every expected word, then let the pipe settle
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] v);
        drain();
        i_cfg_wen   = 1'b1;
        i_cfg_wdata = v;
        sb.set_size(v);
        @(negedge i_clk);
        i_cfg_wen   = 1'b0;
    endtask

    function automatic t_sample pick_sample();
        case ($urandom_range(9))
            6, 7:    return t_sample'($signed($urandom_range(8)) - 4);
            8:       return 16'sh8000;
            9:       return 16'sh7fff;
            default: return t_sample'($urandom);
        endcase
    endfunction

    int          p;
    int          i;
    int          n;
    int          sent;
    int unsigned k;
    bit          clean;
    logic [CFG_W-1:0] sizes [N_PHASES] = '{5'd2, 5'd16, 5'd5, 5'd31, 5'd4, 5'd1,
                                           5'd7, 5'd0, 5'd3, 5'd12, 5'd16, 5'd9};
    int          src_pct [4] = '{0, 64, 0, 7};
    int          snk_pct [4] = '{0, 0, 64, 7};

    initial begin
        sb            = new();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_len      = 0;
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tlast     = 1'b0;
        i_cfg_wen     = 1'b0;
        i_cfg_wdata   = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset size of three: end before full, extremes, end with full window
        send_word(16'sd100, 1'b0);
        send_word(-16'sd5, 1'b1);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh7fff, 1'b0);
        send_word(16'sd0, 1'b0);
        send_word(-16'sd1, 1'b0);
        send_word(16'sh8000, 1'b1);
        write_size(5'd1);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh7fff, 1'b0);
        send_word(16'sd1, 1'b1);
        write_size(5'd0);
        send_word(-16'sd2, 1'b0);
        send_word(16'sd3, 1'b1);

        for (p = 0; p < N_PHASES; p++) begin
            write_size(sizes[p]);
            src_idle_pct  = src_pct[p % 4];
            snk_stall_pct = snk_pct[p % 4];
            k = sb.win_len();
            if (p == 4) begin
                hold_len = 300;
                repeat (40) send_word(pick_sample(), 1'b0);
            end
            sent = 0;
            while (sent < PHASE_LEN) begin
                clean = ($urandom_range(99) < 85);
                n = clean ? k + $urandom_range(2 * k) : $urandom_range(k, 1);
                for (i = 0; i < n; i++)
                    send_word(pick_sample(),
                              clean ? (i == n - 1) : ($urandom_range(3) == 0));
                sent += n;
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("sliding_window_lower_median_core_tb: PASS");
        else
            $display("sliding_window_lower_median_core_tb: FAIL");
        $finish;
    end

endmodule

// ----- sliding_window_lower_median_core.f -----
design/swlm_pkg.sv
design/swlm_cell.sv
design/sliding_window_lower_median_core.sv
design/swlm_checker.sv
tb/sliding_window_lower_median_core_tb.sv
